FILE: rtl/grc_pkg.sv
// shared constants, register map and helpers for the grid raycast column block
// used by grc_div and grid_raycast_column; no dependencies
`timescale 1ns / 1ps
package grc_pkg;

  localparam int MAP_SIZE   = 32;
  localparam int MAX_STEPS  = 64;
  localparam int MAP_CELLS  = MAP_SIZE * MAP_SIZE;
  localparam int MAP_ADDR_W = $clog2(MAP_CELLS);
  localparam int STEP_W     = $clog2(MAX_STEPS + 1);
  // signed cell index: start cell 0..31 plus up to 64 steps either way
  localparam int CELL_W     = 10;

  localparam int DIV_NUM_W  = 32;
  localparam int DIV_DEN_W  = 17;
  localparam int DIV_CNT_W  = $clog2(DIV_NUM_W);

  localparam int PADDR_W    = 5;

  localparam logic [25:0] DELTA_SAT = 26'h3FF_FFFF;
  localparam logic [20:0] LINE_SAT  = 21'h10_0000;
  localparam int          RAY_LIM   = 131071;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] REG_PLAYER_X = 3'd0;
  localparam logic [2:0] REG_PLAYER_Y = 3'd1;
  localparam logic [2:0] REG_DIR_X    = 3'd2;
  localparam logic [2:0] REG_DIR_Y    = 3'd3;
  localparam logic [2:0] REG_PLANE_X  = 3'd4;
  localparam logic [2:0] REG_PLANE_Y  = 3'd5;
  localparam logic [2:0] REG_WIDTH    = 3'd6;
  localparam logic [2:0] REG_HEIGHT   = 3'd7;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  function automatic logic [MAP_ADDR_W-1:0] map_addr(input logic [CELL_W-2:0] row,
                                                     input logic [CELL_W-2:0] col);
    map_addr = MAP_ADDR_W'(int'(row) * MAP_SIZE + int'(col));
  endfunction

endpackage

FILE: rtl/grc_ram.sv
// generic single-port-write, registered-read ram
// no dependencies
`timescale 1ns / 1ps
module grc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/grc_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on grc_pkg
`timescale 1ns / 1ps
module grc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  grc_pkg::div_req_t                 req_i,
  output logic                              done_o,
  output logic [grc_pkg::DIV_NUM_W-1:0]     quot_o
);
  import grc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_NUM_W-1:0] num_q, num_d;
  logic [DIV_DEN_W-1:0] rem_q, rem_d;
  logic [DIV_DEN_W-1:0] den_q, den_d;
  logic [DIV_DEN_W:0]   rem_sh;
  logic                 ge;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    rem_sh = {rem_q, num_q[DIV_NUM_W-1]};
    ge     = rem_sh >= {1'b0, den_q};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      num_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // quotient bits shift in behind the numerator
      num_d = {num_q[DIV_NUM_W-2:0], ge};
      rem_d = ge ? DIV_DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DIV_DEN_W-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(DIV_NUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quot_o = num_q;

endmodule

FILE: rtl/grid_raycast_column.sv
// top level of the grid raycast column block: registers, sequencer, map, divider
// depends on grc_pkg, grc_ram, grc_div
//
// Usage
//   s_axis carries one transaction per item. tuser is the opcode: a map write
//   sets one cell; a cast forms the ray, walks the grid and returns one
//   transaction on m_axis with the wall span for that column.
//   A cast makes up to six passes of the shared divider (two ray terms, two
//   step lengths, distance, line height) and runs the step/map-read/test
//   loop on the map ram for each grid step; a step that leaves the map skips
//   the test.
//   One item is worked on at a time; s_axis_tready is high only when idle.
//   The result sits in an output register, so the next item is accepted while
//   it waits; if the receiver still stalls when the next cast ends, the
//   sequencer holds until the output register frees.
//   After reset the map ram is cleared one cell per cycle; no item is taken
//   meanwhile, register writes are taken at any time.
//   Registers sit on the apb port at byte address 4*index and read back.
`timescale 1ns / 1ps
module grid_raycast_column (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // cell_x[4:0], cell_y[9:5], cell_is_wall[10], screen_column[22:11]
  input  logic [23:0] s_axis_tdata,
  // opcode[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // column_out[11:0], draw_start[23:12], draw_end[35:24], wall_side[36],
  // hit_row[41:37], hit_col[46:42], wall_distance[62:47], forced_hit[63]
  output logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [grc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grc_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_MULX, S_RXGO, S_RXW, S_MULY, S_RYGO, S_RYW,
    S_DXGO, S_DXW, S_DYGO, S_DYW, S_SIDEX, S_SIDEY, S_SIDEZ,
    S_STEP, S_RD, S_CHK, S_DGO, S_DW, S_LGO, S_LW, S_FIN
  } state_e;

  // configuration registers
  logic [14:0]        px_q, py_q;
  logic signed [15:0] dirx_q, diry_q, cpx_q, cpy_q;
  logic [12:0]        sw_q, sh_q;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      px_q   <= 15'd22528;
      py_q   <= 15'd11776;
      dirx_q <= -16'sd16384;
      diry_q <= '0;
      cpx_q  <= '0;
      cpy_q  <= 16'sd16384;
      sw_q   <= 13'd960;
      sh_q   <= 13'd480;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_PLAYER_X: px_q   <= pwdata[14:0];
        REG_PLAYER_Y: py_q   <= pwdata[14:0];
        REG_DIR_X:    dirx_q <= pwdata[15:0];
        REG_DIR_Y:    diry_q <= pwdata[15:0];
        REG_PLANE_X:  cpx_q  <= pwdata[15:0];
        REG_PLANE_Y:  cpy_q  <= pwdata[15:0];
        REG_WIDTH:    sw_q   <= pwdata[12:0];
        REG_HEIGHT:   sh_q   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_PLAYER_X: prdata = {17'd0, px_q};
      REG_PLAYER_Y: prdata = {17'd0, py_q};
      REG_DIR_X:    prdata = {16'd0, dirx_q};
      REG_DIR_Y:    prdata = {16'd0, diry_q};
      REG_PLANE_X:  prdata = {16'd0, cpx_q};
      REG_PLANE_Y:  prdata = {16'd0, cpy_q};
      REG_WIDTH:    prdata = {19'd0, sw_q};
      REG_HEIGHT:   prdata = {19'd0, sh_q};
      default:      prdata = '0;
    endcase
  end

  // sequencer state and datapath registers
  state_e                  state_q;
  logic [MAP_ADDR_W-1:0]   clr_q;
  logic [11:0]             col_q;
  logic [12:0]             w_q, h_q;
  logic signed [14:0]      cm_q;
  logic signed [42:0]      prod_q;
  logic signed [17:0]      rx_q, ry_q;
  logic [25:0]             dx_q, dy_q;
  logic [33:0]             sx_q, sy_q;
  logic signed [CELL_W-1:0] mx_q, my_q;
  logic [STEP_W-1:0]       steps_q;
  logic                    side_q, forced_q;
  logic [15:0]             dist_q;
  logic [20:0]             line_q;
  logic                    m_valid_q;
  logic [63:0]             m_data_q;

  // shared multiplier
  logic signed [26:0] mul_a;
  logic signed [15:0] mul_b;
  logic signed [42:0] mul_p;
  logic [10:0]        fx, fy;

  assign fx = rx_q[17] ? {1'b0, px_q[9:0]} : 11'(11'd1024 - {1'b0, px_q[9:0]});
  assign fy = ry_q[17] ? {1'b0, py_q[9:0]} : 11'(11'd1024 - {1'b0, py_q[9:0]});

  always_comb begin
    case (state_q)
      S_MULX: begin
        mul_a = {{12{cm_q[14]}}, cm_q};
        mul_b = cpx_q;
      end
      S_MULY: begin
        mul_a = {{12{cm_q[14]}}, cm_q};
        mul_b = cpy_q;
      end
      S_SIDEX: begin
        mul_a = $signed({1'b0, dx_q});
        mul_b = $signed({5'd0, fx});
      end
      S_SIDEY: begin
        mul_a = $signed({1'b0, dy_q});
        mul_b = $signed({5'd0, fy});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // magnitudes and the ray term after division
  logic [42:0]        prod_abs;
  logic [16:0]        rxa, rya;
  logic signed [32:0] q_s, ray_sum;
  logic signed [17:0] ray_cl;
  logic signed [15:0] dir_sel;
  logic [DIV_NUM_W-1:0] quot;
  logic               div_done;

  assign prod_abs = prod_q[42] ? 43'(-prod_q) : prod_q;
  assign rxa      = rx_q[17] ? 17'(-rx_q) : rx_q[16:0];
  assign rya      = ry_q[17] ? 17'(-ry_q) : ry_q[16:0];
  assign dir_sel  = (state_q == S_RXW) ? dirx_q : diry_q;

  always_comb begin
    q_s     = prod_q[42] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    ray_sum = {{17{dir_sel[15]}}, dir_sel} + q_s;
    if (ray_sum > 33'sd131071) begin
      ray_cl = 18'(RAY_LIM);
    end else if (ray_sum < -33'sd131071) begin
      ray_cl = 18'(-RAY_LIM);
    end else begin
      ray_cl = ray_sum[17:0];
    end
  end

  // distance numerator on the last stepped axis
  logic signed [CELL_W-1:0] cell_sel;
  logic                     neg_sel;
  logic [14:0]              pos_sel;
  logic signed [CELL_W+11:0] dnum;
  logic [CELL_W+10:0]        dnum_abs;
  logic [16:0]               den_sel;

  assign cell_sel = side_q ? my_q : mx_q;
  assign neg_sel  = side_q ? ry_q[17] : rx_q[17];
  assign pos_sel  = side_q ? py_q : px_q;
  assign den_sel  = side_q ? rya : rxa;
  assign dnum     = $signed({{2{cell_sel[CELL_W-1]}}, cell_sel, 10'd0})
                  + $signed({{(CELL_W+1){1'b0}}, neg_sel, 10'd0})
                  - $signed({{(CELL_W-3){1'b0}}, pos_sel});
  assign dnum_abs = dnum[CELL_W+11] ? (CELL_W+11)'(-dnum) : dnum[CELL_W+10:0];

  // divider requests
  div_req_t div_req;

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = '0;
    div_req.den   = '0;
    case (state_q)
      S_RXGO, S_RYGO: begin
        div_req.start = 1'b1;
        div_req.num   = prod_abs[DIV_NUM_W-1:0];
        div_req.den   = {4'd0, w_q};
      end
      S_DXGO: begin
        div_req.start = (rxa != '0);
        div_req.num   = DIV_NUM_W'(32'h0100_0000);
        div_req.den   = rxa;
      end
      S_DYGO: begin
        div_req.start = (rya != '0);
        div_req.num   = DIV_NUM_W'(32'h0100_0000);
        div_req.den   = rya;
      end
      S_DGO: begin
        div_req.start = (den_sel != '0);
        div_req.num   = DIV_NUM_W'({dnum_abs, 14'd0});
        div_req.den   = den_sel;
      end
      S_LGO: begin
        div_req.start = (dist_q != '0);
        div_req.num   = DIV_NUM_W'({h_q, 10'd0});
        div_req.den   = {1'b0, dist_q};
      end
      default: ;
    endcase
  end

  grc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // map ram: clearing pass, cell writes and walk reads
  logic                  in_acc, cell_ok, ram_we, ram_wdata, ram_rdata;
  logic [MAP_ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [4:0]            in_cx, in_cy;
  logic [11:0]           in_col;

  assign in_cx   = s_axis_tdata[4:0];
  assign in_cy   = s_axis_tdata[9:5];
  assign in_col  = s_axis_tdata[22:11];
  assign in_acc  = s_axis_tvalid & s_axis_tready;
  assign cell_ok = (int'(in_cx) < MAP_SIZE) && (int'(in_cy) < MAP_SIZE);

  always_comb begin
    if (state_q == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = 1'b0;
    end else begin
      ram_we    = in_acc && (s_axis_tuser == OP_WRITE) && cell_ok;
      ram_waddr = map_addr((CELL_W-1)'(in_cx), (CELL_W-1)'(in_cy));
      ram_wdata = s_axis_tdata[10];
    end
  end

  assign ram_raddr = map_addr(mx_q[CELL_W-2:0], my_q[CELL_W-2:0]);

  grc_ram #(
    .WIDTH (1),
    .DEPTH (MAP_CELLS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // final span and clamped hit cell
  logic [11:0]           hh;
  logic [19:0]           lh;
  logic [20:0]           span_hi;
  logic [11:0]           ds, de;
  logic signed [CELL_W-1:0] mx_cl, my_cl;
  logic                  out_free, out_of_map;

  assign hh      = h_q[12:1];
  assign lh      = line_q[20:1];
  assign span_hi = {9'd0, hh} + {1'b0, lh};
  assign ds      = ({8'd0, hh} > lh) ? 12'({8'd0, hh} - lh) : 12'd0;
  assign de      = (span_hi >= {8'd0, h_q}) ? 12'(h_q - 13'd1) : span_hi[11:0];
  assign mx_cl   = mx_q[CELL_W-1] ? '0 :
                   (mx_q > CELL_W'(MAP_SIZE - 1)) ? CELL_W'(MAP_SIZE - 1) : mx_q;
  assign my_cl   = my_q[CELL_W-1] ? '0 :
                   (my_q > CELL_W'(MAP_SIZE - 1)) ? CELL_W'(MAP_SIZE - 1) : my_q;
  assign out_free   = !m_valid_q || m_axis_tready;
  assign out_of_map = mx_q[CELL_W-1] || my_q[CELL_W-1]
                   || (mx_q >= CELL_W'(MAP_SIZE)) || (my_q >= CELL_W'(MAP_SIZE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
      steps_q   <= '0;
    end else begin
      // in the final state the output register is refilled instead
      if (m_valid_q && m_axis_tready && (state_q != S_FIN)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == MAP_ADDR_W'(MAP_CELLS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc && (s_axis_tuser == OP_CAST)) begin
            col_q   <= in_col;
            w_q     <= (sw_q == '0) ? 13'd1 : (sw_q > 13'd4096) ? 13'd4096 : sw_q;
            h_q     <= (sh_q == '0) ? 13'd1 : (sh_q > 13'd4096) ? 13'd4096 : sh_q;
            cm_q    <= $signed({2'b00, in_col, 1'b0})
                     - $signed({2'b00, ((sw_q == '0) ? 13'd1 :
                                        (sw_q > 13'd4096) ? 13'd4096 : sw_q)});
            state_q <= S_MULX;
          end
        end
        S_MULX: begin
          prod_q  <= mul_p;
          state_q <= S_RXGO;
        end
        S_RXGO: state_q <= S_RXW;
        S_RXW: begin
          if (div_done) begin
            rx_q    <= ray_cl;
            state_q <= S_MULY;
          end
        end
        S_MULY: begin
          prod_q  <= mul_p;
          state_q <= S_RYGO;
        end
        S_RYGO: state_q <= S_RYW;
        S_RYW: begin
          if (div_done) begin
            ry_q    <= ray_cl;
            state_q <= S_DXGO;
          end
        end
        S_DXGO: begin
          if (rxa == '0) begin
            dx_q    <= DELTA_SAT;
            state_q <= S_DYGO;
          end else begin
            state_q <= S_DXW;
          end
        end
        S_DXW: begin
          if (div_done) begin
            dx_q    <= quot[25:0];
            state_q <= S_DYGO;
          end
        end
        S_DYGO: begin
          if (rya == '0) begin
            dy_q    <= DELTA_SAT;
            state_q <= S_SIDEX;
          end else begin
            state_q <= S_DYW;
          end
        end
        S_DYW: begin
          if (div_done) begin
            dy_q    <= quot[25:0];
            state_q <= S_SIDEX;
          end
        end
        S_SIDEX: begin
          prod_q  <= mul_p;
          state_q <= S_SIDEY;
        end
        S_SIDEY: begin
          sx_q    <= {7'd0, prod_q[36:10]};
          prod_q  <= mul_p;
          state_q <= S_SIDEZ;
        end
        S_SIDEZ: begin
          sy_q     <= {7'd0, prod_q[36:10]};
          mx_q     <= CELL_W'(px_q[14:10]);
          my_q     <= CELL_W'(py_q[14:10]);
          steps_q  <= '0;
          forced_q <= 1'b0;
          side_q   <= 1'b0;
          state_q  <= S_STEP;
        end
        S_STEP: begin
          // advance the axis whose side distance is smaller, y on a tie
          if (sx_q < sy_q) begin
            sx_q   <= sx_q + {8'd0, dx_q};
            mx_q   <= rx_q[17] ? mx_q - 1'b1 : mx_q + 1'b1;
            side_q <= 1'b0;
          end else begin
            sy_q   <= sy_q + {8'd0, dy_q};
            my_q   <= ry_q[17] ? my_q - 1'b1 : my_q + 1'b1;
            side_q <= 1'b1;
          end
          steps_q <= steps_q + 1'b1;
          state_q <= S_RD;
        end
        S_RD: begin
          if (out_of_map) begin
            forced_q <= 1'b1;
            state_q  <= S_DGO;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          if (ram_rdata) begin
            state_q <= S_DGO;
          end else if (steps_q == STEP_W'(MAX_STEPS)) begin
            forced_q <= 1'b1;
            state_q  <= S_DGO;
          end else begin
            state_q <= S_STEP;
          end
        end
        S_DGO: begin
          if (den_sel == '0) begin
            dist_q  <= 16'hFFFF;
            state_q <= S_LGO;
          end else begin
            state_q <= S_DW;
          end
        end
        S_DW: begin
          if (div_done) begin
            dist_q  <= (quot > 32'h0000_FFFF) ? 16'hFFFF : quot[15:0];
            state_q <= S_LGO;
          end
        end
        S_LGO: begin
          if (dist_q == '0) begin
            line_q  <= LINE_SAT;
            state_q <= S_FIN;
          end else begin
            state_q <= S_LW;
          end
        end
        S_LW: begin
          if (div_done) begin
            line_q  <= (quot > 32'(LINE_SAT)) ? LINE_SAT : quot[20:0];
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {forced_q, dist_q, my_cl[4:0], mx_cl[4:0], side_q, de, ds, col_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !s_axis_tready)
    else $error("item accepted during map clear");

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_RXW || state_q == S_RYW || state_q == S_DXW ||
                  state_q == S_DYW || state_q == S_DW || state_q == S_LW))
    else $error("divider result outside a wait state");

  a_step_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    steps_q <= STEP_W'(MAX_STEPS))
    else $error("walk ran past the step cap");

  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_FIN))
    else $error("result raised outside the final state");

endmodule

FILE: bench/grc_checker.sv
// result checker for grid_raycast_column: watches apb writes, s_axis and m_axis,
// keeps its own camera registers and wall map, predicts each cast and compares
`timescale 1ns / 1ps
module grc_checker (
  input  logic        clk_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [63:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [grc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          pending_o
);
  import grc_pkg::*;

  typedef struct packed {
    logic        forced_hit;
    logic [15:0] wall_distance;
    logic [4:0]  hit_col;
    logic [4:0]  hit_row;
    logic        wall_side;
    logic [11:0] draw_end;
    logic [11:0] draw_start;
    logic [11:0] column_out;
  } span_t;

  logic [14:0] cam_x, cam_y;
  shortint     dir_x, dir_y, plane_x, plane_y;
  logic [12:0] scr_w, scr_h;
  logic        wall_cells [MAP_CELLS];
  span_t       span_q[$];
  int          fails;

  initial begin
    cam_x = 15'd22528;
    cam_y = 15'd11776;
    dir_x = -16384;
    dir_y = 0;
    plane_x = 0;
    plane_y = 16384;
    scr_w = 13'd960;
    scr_h = 13'd480;
    fails = 0;
    foreach (wall_cells[i]) wall_cells[i] = 1'b0;
  end

  assign fail_count_o = fails;
  assign pending_o    = span_q.size();

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  // perpendicular distance along one axis from the start to the crossed wall face
  function automatic longint perp_dist(longint cell_idx, longint stp, longint pos,
                                       longint r);
    longint num, d;
    num = cell_idx * 1024 + (stp < 0 ? 1024 : 0) - pos;
    if (r == 0) return 65535;
    d = absl(num) * 16384 / absl(r);
    return d > 65535 ? 65535 : d;
  endfunction

  function automatic span_t cast_column(logic [11:0] column);
    longint w, h, c, px, py, rx, ry, dx, dy, sx, sy, mx, my, stx, sty;
    longint perp, line, ds, de;
    int side, forced, hit;
    span_t s;
    side = 0;
    forced = 0;
    hit = 0;
    c = longint'(column);
    w = clampl(longint'(scr_w), 1, 4096);
    h = clampl(longint'(scr_h), 1, 4096);
    px = longint'(cam_x);
    py = longint'(cam_y);
    rx = clampl(longint'(dir_x) + longint'(plane_x) * (2 * c - w) / w, -RAY_LIM, RAY_LIM);
    ry = clampl(longint'(dir_y) + longint'(plane_y) * (2 * c - w) / w, -RAY_LIM, RAY_LIM);
    mx = px >> 10;
    my = py >> 10;
    dx = rx == 0 ? longint'(DELTA_SAT) : 16777216 / absl(rx);
    dy = ry == 0 ? longint'(DELTA_SAT) : 16777216 / absl(ry);
    if (rx < 0) begin
      stx = -1;
      sx = (px & 1023) * dx / 1024;
    end else begin
      stx = 1;
      sx = (1024 - (px & 1023)) * dx / 1024;
    end
    if (ry < 0) begin
      sty = -1;
      sy = (py & 1023) * dy / 1024;
    end else begin
      sty = 1;
      sy = (1024 - (py & 1023)) * dy / 1024;
    end
    for (int n = 0; n < MAX_STEPS && hit == 0; n++) begin
      if (sx < sy) begin
        sx += dx;
        mx += stx;
        side = 0;
      end else begin
        sy += dy;
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= MAP_SIZE || my < 0 || my >= MAP_SIZE) begin
        hit = 1;
        forced = 1;
      end else if (wall_cells[mx * MAP_SIZE + my]) begin
        hit = 1;
      end
    end
    if (hit == 0) forced = 1;
    perp = side == 0 ? perp_dist(mx, stx, px, rx) : perp_dist(my, sty, py, ry);
    line = perp == 0 ? longint'(LINE_SAT) : h * 1024 / perp;
    if (line > longint'(LINE_SAT)) line = longint'(LINE_SAT);
    ds = h / 2 - line / 2;
    if (ds < 0) ds = 0;
    de = h / 2 + line / 2;
    if (de >= h) de = h - 1;
    s.column_out    = column;
    s.draw_start    = ds[11:0];
    s.draw_end      = de[11:0];
    s.wall_side     = side[0];
    s.hit_row       = 5'(clampl(mx, 0, MAP_SIZE - 1));
    s.hit_col       = 5'(clampl(my, 0, MAP_SIZE - 1));
    s.wall_distance = perp[15:0];
    s.forced_hit    = forced[0];
    return s;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      fails++;
    end
  endfunction

  always @(posedge clk_i) begin
    span_t got, want;
    if (psel && penable && pwrite && pready) begin
      case (paddr[4:2])
        REG_PLAYER_X: cam_x   = pwdata[14:0];
        REG_PLAYER_Y: cam_y   = pwdata[14:0];
        REG_DIR_X:    dir_x   = shortint'(pwdata[15:0]);
        REG_DIR_Y:    dir_y   = shortint'(pwdata[15:0]);
        REG_PLANE_X:  plane_x = shortint'(pwdata[15:0]);
        REG_PLANE_Y:  plane_y = shortint'(pwdata[15:0]);
        REG_WIDTH:    scr_w   = pwdata[12:0];
        REG_HEIGHT:   scr_h   = pwdata[12:0];
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) begin
      if (s_axis_tuser == OP_WRITE)
        wall_cells[int'(s_axis_tdata[4:0]) * MAP_SIZE + int'(s_axis_tdata[9:5])] =
          s_axis_tdata[10];
      else
        span_q.push_back(cast_column(s_axis_tdata[22:11]));
    end
    if (m_axis_tvalid && m_axis_tready) begin
      got = span_t'(m_axis_tdata);
      if (span_q.size() == 0) begin
        $error("result transaction with no cast outstanding: %h", m_axis_tdata);
        fails++;
      end else begin
        want = span_q.pop_front();
        check_field("column_out", want.column_out, got.column_out);
        check_field("draw_start", want.draw_start, got.draw_start);
        check_field("draw_end", want.draw_end, got.draw_end);
        check_field("wall_side", want.wall_side, got.wall_side);
        check_field("hit_row", want.hit_row, got.hit_row);
        check_field("hit_col", want.hit_col, got.hit_col);
        check_field("wall_distance", want.wall_distance, got.wall_distance);
        check_field("forced_hit", want.forced_hit, got.forced_hit);
      end
    end
  end

endmodule

FILE: bench/tb_grid_raycast_column.sv
// stimulus top for grid_raycast_column: clock, reset, apb camera setup, map writes
// and column casts with random gaps; depends on grc_pkg, the block and grc_checker
`timescale 1ns / 1ps
module tb_grid_raycast_column;
  import grc_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 500;
  localparam int HOLD_CYCLES    = 900;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OP_WRITE;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending;
  int          idle_cycles = 0;
  bit          hold_request = 1'b0;
  bit          no_gaps = 1'b0;
  bit          out_no_gaps = 1'b0;
  bit          run_done = 1'b0;
  logic [12:0] cur_width = 13'd960;

  always #2 clk_i = ~clk_i;

  grid_raycast_column dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  grc_checker u_checker (
    .clk_i, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    int g;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      g = out_no_gaps ? 0 : pick_gap();
      if (g == 0) begin
        m_axis_tready = 1'b1;
      end else begin
        m_axis_tready = 1'b0;
        repeat (g - 1) @(negedge clk_i);
      end
    end
  end

  // watchdog: cycles without any transaction on any port
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable) || run_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic apb_write(input logic [2:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx == REG_WIDTH) cur_width = value[12:0];
  endtask

  // returns at the falling edge after the transaction, tvalid still high
  task automatic send_item(input logic op, input logic [4:0] cx, input logic [4:0] cy,
                           input logic wall, input logic [11:0] column);
    int g;
    g = no_gaps ? 0 : pick_gap();
    if (g > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tuser = op;
    s_axis_tdata = {1'b0, column, wall, cy, cx};
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  task automatic cast(input logic [11:0] column);
    send_item(OP_CAST, 5'($urandom()), 5'($urandom()), 1'($urandom()), column);
  endtask

  task automatic set_cell(input int x, input int y, input logic wall);
    send_item(OP_WRITE, x[4:0], y[4:0], wall, 12'($urandom()));
  endtask

  // quiet both channels before touching the camera registers
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_camera(input int px, input int py, input int dx, input int dy,
                            input int qx, input int qy, input int w, input int h);
    apb_write(REG_PLAYER_X, px);
    apb_write(REG_PLAYER_Y, py);
    apb_write(REG_DIR_X, dx);
    apb_write(REG_DIR_Y, dy);
    apb_write(REG_PLANE_X, qx);
    apb_write(REG_PLANE_Y, qy);
    apb_write(REG_WIDTH, w);
    apb_write(REG_HEIGHT, h);
  endtask

  function automatic logic [11:0] pick_column();
    int w;
    w = cur_width == 0 ? 1 : (cur_width > 4096 ? 4096 : int'(cur_width));
    if ($urandom_range(0, 9) == 0) return 12'($urandom());
    return 12'($urandom_range(0, w - 1));
  endfunction

  initial begin
    int ph, items;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: default camera into an open map leaves the map
    cast(12'd0);
    cast(12'd480);
    cast(12'd959);
    cast(12'd4095);
    set_cell(0, 0, 1'b1);
    set_cell(31, 31, 1'b1);
    set_cell(20, 11, 1'b1);
    cast(12'd480);
    set_cell(20, 11, 1'b0);
    set_cell(16, 11, 1'b1);
    cast(12'd480);
    cast(12'd100);
    settle();
    // zero ray on both axes: saturated deltas and distance
    set_camera(0, 0, 0, 0, 0, 0, 8191, 0);
    cast(12'd0);
    cast(12'd4095);
    settle();
    // right against a wall: zero distance, full span
    set_camera(32767, 32767, -32768, 32767, 32767, -32768, 1, 4096);
    set_cell(1, 1, 1'b1);
    cast(12'd0);
    cast(12'd1);
    settle();
    set_camera(17 * 1024, 11 * 1024, 16384, 0, 0, 16384, 4096, 4096);
    cast(12'd0);
    cast(12'd4095);
    cast(12'd2048);
    cast(12'd1);

    // random phases: build a map, then cast across the screen
    for (ph = 0; ph < 6; ph++) begin
      settle();
      if (ph == 2)
        set_camera($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                   $urandom(), $urandom(), $urandom());
      else
        set_camera($urandom_range(1024, 31743), $urandom_range(1024, 31743),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(1, 4096), $urandom_range(1, 4096));
      no_gaps = (ph == 3);
      out_no_gaps = (ph == 4);
      if (ph == 1) hold_request = 1'b1;
      // border-ring walls and sparse random cells written over the existing map, then casts
      for (items = 0; items < 140; items++) begin
        if (items < 40 || $urandom_range(0, 4) == 0) begin
          if (ph != 5 && $urandom_range(0, 2) == 0) begin
            if ($urandom_range(0, 1)) set_cell($urandom_range(0, 1) * 31, $urandom(), 1'b1);
            else set_cell($urandom(), $urandom_range(0, 1) * 31, 1'b1);
          end else begin
            set_cell($urandom(), $urandom(), $urandom_range(0, 3) == 0);
          end
        end else begin
          cast(pick_column());
        end
      end
    end

    settle();
    run_done = 1'b1;
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
